@@ rtl/drs_pkg.sv @@
// Shared constants, state encoding and controller/datapath interface types of the depth sorter.
package drs_pkg;

   // Store geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;
   localparam int REC_W    = 3 * WORD_W;

   // Controller states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // store one accepted item
      logic run_init;   // start a new sorted run
      logic scan_init;  // start a new pass over the store
      logic scan_run;   // issue one store read
      logic emit;       // present the pass winner as a result
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic issue_last; // read of the last stored entry is being issued
      logic emit_last;  // the result being emitted closes the run
   } status_type;

endpackage

@@ rtl/drs_ctrl.sv @@
// Controller state machine: loading, scan passes and result emission of the depth sorter.
module drs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                last_in,
   input  drs_pkg::status_type status,
   output drs_pkg::cmd_type    cmd,
   output logic                busy
);

   drs_pkg::state_type state_ff;
   drs_pkg::state_type state_in;
   logic               accept;

   assign accept = start && !busy;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drs_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drs_pkg::ST_LOAD: begin
            if (accept && last_in) begin
               state_in = drs_pkg::ST_SCAN;
            end
         end
         drs_pkg::ST_SCAN: begin
            if (status.issue_last) begin
               state_in = drs_pkg::ST_DRAIN;
            end
         end
         drs_pkg::ST_DRAIN: begin
            state_in = drs_pkg::ST_EMIT;
         end
         drs_pkg::ST_EMIT: begin
            if (status.emit_last) begin
               state_in = drs_pkg::ST_LOAD;
            end else begin
               state_in = drs_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = drs_pkg::ST_LOAD;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         drs_pkg::ST_LOAD: begin
            busy          = 1'b0;
            cmd.load      = start;
            cmd.run_init  = start && last_in;
            cmd.scan_init = start && last_in;
         end
         drs_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         drs_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         drs_pkg::ST_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.scan_init = !status.emit_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/drs_datapath.sv @@
// Datapath: record store, count and overflow flag, scan compare and result registers.
module drs_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  drs_pkg::cmd_type                  cmd,
   output drs_pkg::status_type               status,
   input  logic signed [drs_pkg::WORD_W-1:0] req_tag_first,
   input  logic signed [drs_pkg::WORD_W-1:0] req_depth_key,
   input  logic signed [drs_pkg::WORD_W-1:0] req_tag_second,
   output logic                              rsp_strobe,
   output logic signed [drs_pkg::WORD_W-1:0] rsp_out_first,
   output logic signed [drs_pkg::WORD_W-1:0] rsp_out_key,
   output logic signed [drs_pkg::WORD_W-1:0] rsp_out_second,
   output logic                              rsp_last_out,
   output logic                              rsp_overflowed
);

   localparam int W  = drs_pkg::WORD_W;
   localparam int IW = drs_pkg::IDX_W;
   localparam int CW = drs_pkg::CNT_W;

   // Record store: {first, adjusted key, second}
   logic [drs_pkg::REC_W-1:0] mem [drs_pkg::CAPACITY];
   logic [drs_pkg::REC_W-1:0] rd_data_ff;
   logic                      rd_vld_ff;
   logic [IW-1:0]             rd_idx_ff;

   logic [CW-1:0]  count_ff;
   logic           ovf_ff;
   logic [CW-1:0]  cnt_m1;
   logic           has_room;
   logic [W-1:0]   adj_key;

   logic [IW-1:0]  scan_cnt_ff;
   logic [IW-1:0]  emit_cnt_ff;
   logic           first_pass_ff;
   logic           found_ff;

   logic signed [W-1:0] best_key_ff;
   logic [W-1:0]        best_first_ff;
   logic [W-1:0]        best_second_ff;
   logic [IW-1:0]       best_idx_ff;
   logic signed [W-1:0] prev_key_ff;
   logic [IW-1:0]       prev_idx_ff;

   logic signed [W-1:0] rd_key;
   logic                eligible;
   logic                better;

   assign cnt_m1   = count_ff - CW'(1);
   assign has_room = count_ff < CW'(drs_pkg::CAPACITY);
   assign adj_key  = req_depth_key + W'(count_ff);

   assign status.issue_last = scan_cnt_ff == cnt_m1[IW-1:0];
   assign status.emit_last  = emit_cnt_ff == cnt_m1[IW-1:0];

   // Store write on load, registered read during scans
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         mem[count_ff[IW-1:0]] <= {req_tag_first, adj_key, req_tag_second};
      end
      rd_data_ff <= mem[scan_cnt_ff];
      rd_idx_ff  <= scan_cnt_ff;
   end

   // Record count and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.emit && status.emit_last) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (has_room) begin
            count_ff <= count_ff + CW'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // Candidate must rank below the previous winner (key descending, index ascending)
   assign rd_key   = rd_data_ff[2*W-1:W];
   assign eligible = first_pass_ff || (rd_key < prev_key_ff) ||
                     ((rd_key == prev_key_ff) && (rd_idx_ff > prev_idx_ff));
   // Entries arrive in index order, so only a strictly larger key wins a tie-free race
   assign better   = !found_ff || (rd_key > best_key_ff);

   // Scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff   <= '0;
         emit_cnt_ff   <= '0;
         first_pass_ff <= 1'b0;
         found_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_run;
         if (cmd.scan_init) begin
            scan_cnt_ff <= '0;
         end else if (cmd.scan_run) begin
            scan_cnt_ff <= scan_cnt_ff + IW'(1);
         end
         if (cmd.scan_init) begin
            found_ff <= 1'b0;
         end else if (rd_vld_ff && eligible) begin
            found_ff <= 1'b1;
         end
         if (cmd.run_init) begin
            first_pass_ff <= 1'b1;
            emit_cnt_ff   <= '0;
         end else if (cmd.emit) begin
            first_pass_ff <= 1'b0;
            emit_cnt_ff   <= emit_cnt_ff + IW'(1);
         end
      end
   end

   // Pass winner and previous winner
   always_ff @(posedge clock) begin
      if (rd_vld_ff && eligible && better) begin
         best_first_ff  <= rd_data_ff[3*W-1:2*W];
         best_key_ff    <= rd_key;
         best_second_ff <= rd_data_ff[W-1:0];
         best_idx_ff    <= rd_idx_ff;
      end
      if (cmd.emit) begin
         prev_key_ff <= best_key_ff;
         prev_idx_ff <= best_idx_ff;
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_out_first  <= best_first_ff;
         rsp_out_key    <= best_key_ff;
         rsp_out_second <= best_second_ff;
         rsp_last_out   <= status.emit_last;
         rsp_overflowed <= ovf_ff;
      end
   end

endmodule

@@ rtl/depth_record_sorter.sv @@
// Top level of the depth sorter: controller and datapath.
//
//   channel  ports                       handshake
//   ------   --------------------------  ------------------------------------
//   request  req_*, start, busy          item taken when start & !busy
//   result   rsp_*, rsp_strobe           item valid for one cycle on strobe
//
// Loading accepts one item per cycle. After the item marked last, busy stays high
// while the n stored records are emitted; each result costs one selection pass
// over the single-read-port record store. Reset clears the count, the overflow
// flag and the controller; the store itself is not cleared. The receiver cannot
// stall the result channel.
module depth_record_sorter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [drs_pkg::WORD_W-1:0] req_tag_first,
   input  logic signed [drs_pkg::WORD_W-1:0] req_depth_key,
   input  logic signed [drs_pkg::WORD_W-1:0] req_tag_second,
   input  logic                              req_last_in,
   output logic                              rsp_strobe,
   output logic signed [drs_pkg::WORD_W-1:0] rsp_out_first,
   output logic signed [drs_pkg::WORD_W-1:0] rsp_out_key,
   output logic signed [drs_pkg::WORD_W-1:0] rsp_out_second,
   output logic                              rsp_last_out,
   output logic                              rsp_overflowed
);

   drs_pkg::cmd_type    cmd;
   drs_pkg::status_type status;

   // Sequencer
   drs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .last_in (req_last_in),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   // Store and selection datapath
   drs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_tag_first  (req_tag_first),
      .req_depth_key  (req_depth_key),
      .req_tag_second (req_tag_second),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_first  (rsp_out_first),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_second (rsp_out_second),
      .rsp_last_out   (rsp_last_out),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

@@ tb/sv/depth_sort_board_pkg.sv @@
// Scoreboard class of the depth sorter test: predicts sorted runs and checks results.
`timescale 1ns / 100ps
package depth_sort_board_pkg;

   typedef struct {
      logic signed [drs_pkg::WORD_W-1:0] first;
      logic signed [drs_pkg::WORD_W-1:0] key;
      logic signed [drs_pkg::WORD_W-1:0] second;
      logic                              last;
      logic                              ovf;
   } depth_rec_type;

   class depth_sort_board;
      depth_rec_type held[$];        // records stored for the current list
      depth_rec_type sorted_due[$];  // emitted records still to arrive, oldest first
      bit            dropped;        // a record of the current list was lost
      int            mismatches;
      int            records_seen;
      int            results_seen;
      int            runs_done;
      int            overflow_runs;

      function int pending();
         return sorted_due.size();
      endfunction

      // Note one accepted item; on the last one queue the whole sorted run
      function void take_record(logic signed [drs_pkg::WORD_W-1:0] first,
                                logic signed [drs_pkg::WORD_W-1:0] key,
                                logic signed [drs_pkg::WORD_W-1:0] second,
                                logic last);
         depth_rec_type rec;
         depth_rec_type run[$];
         int            pos;
         records_seen++;
         if (held.size() < drs_pkg::CAPACITY) begin
            rec.first  = first;
            rec.key    = key + held.size();  // load index added, 32-bit wrap
            rec.second = second;
            rec.last   = 1'b0;
            rec.ovf    = 1'b0;
            held.push_back(rec);
         end else begin
            dropped = 1'b1;
         end
         if (!last)
            return;
         // insertion keeps load order among equal keys
         foreach (held[i]) begin
            pos = run.size();
            while (pos > 0 && held[i].key > run[pos-1].key)
               pos--;
            run.insert(pos, held[i]);
         end
         foreach (run[i]) begin
            run[i].last = (i == run.size() - 1);
            run[i].ovf  = dropped;
            sorted_due.push_back(run[i]);
         end
         runs_done++;
         if (dropped)
            overflow_runs++;
         held.delete();
         dropped = 1'b0;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40)
            $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_field(string name, logic [drs_pkg::WORD_W-1:0] got,
                       logic [drs_pkg::WORD_W-1:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
      endtask

      // Compare one emitted result with the oldest expectation
      task check_emitted(logic signed [drs_pkg::WORD_W-1:0] first,
                         logic signed [drs_pkg::WORD_W-1:0] key,
                         logic signed [drs_pkg::WORD_W-1:0] second,
                         logic last, logic ovf);
         depth_rec_type want;
         results_seen++;
         if (sorted_due.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = sorted_due.pop_front();
            check_field("out_first", first, want.first);
            check_field("out_key", key, want.key);
            check_field("out_second", second, want.second);
            check_field("last_out", last, want.last);
            check_field("overflowed", ovf, want.ovf);
         end
      endtask
   endclass

endpackage

@@ tb/sv/depth_record_sorter_test.sv @@
// Top of the depth sorter test: clock, reset, item driver, result monitor and watchdog.
`timescale 1ns / 100ps
module depth_record_sorter_test;

   localparam int QUIET_LIMIT   = 4000;               // idle cycles before giving up
   localparam int SETTLE_CYCLES = 3 * (drs_pkg::CAPACITY + 2); // watch for stray results
   localparam int RANDOM_ITEMS  = 110;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic signed [drs_pkg::WORD_W-1:0] req_tag_first;
   logic signed [drs_pkg::WORD_W-1:0] req_depth_key;
   logic signed [drs_pkg::WORD_W-1:0] req_tag_second;
   logic                              req_last_in;
   logic                              rsp_strobe;
   logic signed [drs_pkg::WORD_W-1:0] rsp_out_first;
   logic signed [drs_pkg::WORD_W-1:0] rsp_out_key;
   logic signed [drs_pkg::WORD_W-1:0] rsp_out_second;
   logic                              rsp_last_out;
   logic                              rsp_overflowed;

   depth_sort_board_pkg::depth_sort_board board;
   int                                    quiet;
   int                                    random_taken;
   int                                    list_no;

   depth_record_sorter dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_tag_first  (req_tag_first),
      .req_depth_key  (req_depth_key),
      .req_tag_second (req_tag_second),
      .req_last_in    (req_last_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_first  (rsp_out_first),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_second (rsp_out_second),
      .rsp_last_out   (rsp_last_out),
      .rsp_overflowed (rsp_overflowed)
   );

   always #5 clock = ~clock;

   // Monitor: check results, note accepted items, watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else begin
         if (rsp_strobe)
            board.check_emitted(rsp_out_first, rsp_out_key, rsp_out_second,
                                rsp_last_out, rsp_overflowed);
         if (start && !busy)
            board.take_record(req_tag_first, req_depth_key, req_tag_second, req_last_in);
         if (rsp_strobe || (start && !busy))
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // No gap when steady; otherwise mostly no gap, some short ones, a few long
   function int unsigned pick_gap(bit steady);
      int unsigned roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function logic [drs_pkg::WORD_W-1:0] corner_word();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function logic [drs_pkg::WORD_W-1:0] tag_word();
      if ($urandom_range(0, 7) == 0)
         return corner_word();
      return $urandom;
   endfunction

   // Present one item and hold it until the block takes it
   task send_record(input logic [drs_pkg::WORD_W-1:0] first,
                    input logic [drs_pkg::WORD_W-1:0] key,
                    input logic [drs_pkg::WORD_W-1:0] second, input logic last);
      start          <= 1'b1;
      req_tag_first  <= first;
      req_depth_key  <= key;
      req_tag_second <= second;
      req_last_in    <= last;
      do @(posedge clock); while (busy);
   endtask

   task rest(input int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Hold off until every queued result has come back
   task drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0 || busy);
   endtask

   task send_random_list(input int unsigned size);
      bit                         steady;
      int unsigned                base;
      logic [drs_pkg::WORD_W-1:0] key;
      steady = ($urandom_range(0, 3) == 0);
      base   = $urandom;
      for (int i = 0; i < size; i++) begin
         case ($urandom_range(0, 4))
            0, 1: key = $urandom;
            2:    key = $urandom_range(0, 15);
            3:    key = base - i;  // equal after the index is added
            default: key = corner_word();
         endcase
         send_record(tag_word(), key, tag_word(), i == size - 1);
         rest(pick_gap(steady));
      end
      random_taken += size;
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_tag_first  <= '0;
      req_depth_key  <= '0;
      req_tag_second <= '0;
      req_last_in    <= 1'b0;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single-record list with extreme words
      send_record(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
      rest(2);
      // largest key at index one wraps to the most negative
      send_record(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_record(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
      send_record(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_record(32'h5555_5555, 32'h0000_0000, 32'hAAAA_AAAA, 1'b1);
      drain();
      // keys falling by one: all adjusted keys tie, load order kept
      for (int i = 0; i < 6; i++) begin
         send_record(i, 100 - i, ~i, i == 5);
         rest(pick_gap(1'b0));
      end
      // rising negative keys come out reversed
      for (int i = 0; i < 5; i++) begin
         send_record(32'h1000_0000 + i, -50 + 7 * i, 32'h2000_0000 - i, i == 4);
         rest(pick_gap(1'b0));
      end
      // two most negative keys: index makes the second larger
      send_record(32'hDEAD_0001, 32'h8000_0000, 32'h0000_0000, 1'b0);
      send_record(32'hDEAD_0002, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      rest(1);

      // random lists, one filling the store and then overflowing it
      random_taken = 0;
      list_no      = 0;
      while (random_taken < RANDOM_ITEMS) begin
         if (list_no == 1)
            send_random_list(drs_pkg::CAPACITY + $urandom_range(1, 3));
         else if ($urandom_range(0, 5) == 0)
            send_random_list($urandom_range(9, 20));
         else
            send_random_list($urandom_range(1, 8));
         if (list_no == 2 || $urandom_range(0, 4) == 0)
            drain();
         list_no++;
      end

      // let every run finish, then watch for stray results
      start <= 1'b0;
      while (board.pending() != 0 || busy)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d records in %0d lists; checked %0d sorted results",
               board.records_seen, board.runs_done, board.results_seen);
      $display("%0d lists exceeded the %0d-entry store", board.overflow_runs,
               drs_pkg::CAPACITY);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/drs_pkg.sv
rtl/drs_ctrl.sv
rtl/drs_datapath.sv
rtl/depth_record_sorter.sv
tb/sv/depth_sort_board_pkg.sv
tb/sv/depth_record_sorter_test.sv
